// File: hdl/wsu_pkg.sv
// Shared types and constants for the WebSocket frame unmasker.
`default_nettype none

package wsu_pkg;

  // Header constants
  localparam logic [7:0] HDR_FIRST_BYTE  = 8'h81;   // final text frame
  localparam logic [7:0] LEN_CODE_MASK   = 8'h7F;
  localparam logic [6:0] LEN_MAX_DIRECT  = 7'd125;
  localparam logic [6:0] LEN_EXT16       = 7'd126;
  localparam logic [6:0] LEN_EXT64       = 7'd127;

  // Extended length bytes still to come after the first, per length code
  localparam logic [2:0] EXT16_REMAIN    = 3'd1;
  localparam logic [2:0] EXT64_REMAIN    = 3'd7;

  localparam int unsigned LEN_W          = 24;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 24'd5120;

  // Result kinds
  localparam logic [1:0] KIND_DATA       = 2'd0;
  localparam logic [1:0] KIND_EMPTY      = 2'd1;
  localparam logic [1:0] KIND_BADHEAD    = 2'd2;
  localparam logic [1:0] KIND_TOOLONG    = 2'd3;

  typedef enum logic [5:0] {
    PH_FIRST = 6'b000001,
    PH_LEN   = 6'b000010,
    PH_EXT   = 6'b000100,
    PH_MASK  = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_ERR   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       last_of_frame;
  } result_t;

endpackage : wsu_pkg

`default_nettype wire

// File: hdl/wsu_in_reg.sv
// Input register stage: holds one accepted byte until the core takes it.
`default_nettype none

module wsu_in_reg
  import wsu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic     in_restart,
  input  wire logic     adv,
  output logic          item_vld,
  output in_item_t      item
);

  logic     vld_r;
  logic     vld_nxt;
  in_item_t item_r;

  assign in_ready = !vld_r || adv;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data_byte <= in_data_byte;
      item_r.restart   <= in_restart;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule : wsu_in_reg

`default_nettype wire

// File: hdl/wsu_core.sv
// Frame parser state and per-byte step logic: header, length, mask, unmask.
`default_nettype none

module wsu_core
  import wsu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire in_item_t         item,
  input  wire logic [LEN_W-1:0] max_payload,
  output result_t               res,
  output logic                  err_hold
);

  phase_t            phase_r,  phase_nxt;
  logic [2:0]        ext_r,    ext_nxt;
  logic [LEN_W-1:0]  len_lo_r, len_lo_nxt;
  logic              len_hi_r, len_hi_nxt;   // any length bit above the low 24 set
  logic [31:0]       key_r,    key_nxt;
  logic [1:0]        pos_r,    pos_nxt;
  logic [LEN_W-1:0]  left_r,   left_nxt;

  phase_t            ph;
  logic [2:0]        ext_e;
  logic [1:0]        pos_e;
  logic [LEN_W-1:0]  left_e;
  logic [6:0]        code;
  logic [LEN_W-1:0]  lo_cand;
  logic              hi_cand;
  logic              too_long;
  logic [7:0]        mask_byte;
  logic              emit;
  logic [1:0]        kind;
  logic [7:0]        pbyte;
  logic              last;

  // Restart clears position before the byte is handled
  assign ph     = item.restart ? PH_FIRST : phase_r;
  assign ext_e  = item.restart ? 3'd0 : ext_r;
  assign pos_e  = item.restart ? 2'd0 : pos_r;
  assign left_e = item.restart ? '0 : left_r;

  assign code = item.data_byte[6:0] & LEN_CODE_MASK[6:0];

  // Length candidate once complete: direct code, or shifted extended length
  always_comb begin
    if (ph == PH_LEN) begin
      lo_cand = {{(LEN_W-7){1'b0}}, code};
      hi_cand = 1'b0;
    end else begin
      lo_cand = {len_lo_r[LEN_W-9:0], item.data_byte};
      hi_cand = len_hi_r || (|len_lo_r[LEN_W-1:LEN_W-8]);
    end
  end

  assign too_long = hi_cand || (lo_cand > max_payload);

  always_comb begin
    case (pos_e)
      2'd0:    mask_byte = key_r[31:24];
      2'd1:    mask_byte = key_r[23:16];
      2'd2:    mask_byte = key_r[15:8];
      default: mask_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = ph;
    ext_nxt    = ext_e;
    len_lo_nxt = len_lo_r;
    len_hi_nxt = len_hi_r;
    key_nxt    = key_r;
    pos_nxt    = pos_e;
    left_nxt   = left_e;
    emit       = 1'b0;
    kind       = KIND_DATA;
    pbyte      = 8'd0;
    last       = 1'b0;
    case (ph)
      PH_FIRST: begin
        if (item.data_byte != HDR_FIRST_BYTE) begin
          phase_nxt = PH_ERR;
          emit      = 1'b1;
          kind      = KIND_BADHEAD;
        end else begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN, PH_EXT: begin
        len_lo_nxt = lo_cand;
        len_hi_nxt = hi_cand;
        if ((ph == PH_LEN && code > LEN_MAX_DIRECT) || (ph == PH_EXT && ext_e != 3'd0)) begin
          if (ph == PH_LEN) begin
            len_lo_nxt = '0;
            ext_nxt    = (code == LEN_EXT16) ? EXT16_REMAIN : EXT64_REMAIN;
            phase_nxt  = PH_EXT;
          end else begin
            ext_nxt = ext_e - 3'd1;
          end
        end else if (too_long) begin
          phase_nxt = PH_ERR;
          emit      = 1'b1;
          kind      = KIND_TOOLONG;
        end else begin
          left_nxt  = lo_cand;
          pos_nxt   = 2'd0;
          key_nxt   = 32'd0;
          phase_nxt = PH_MASK;
        end
      end
      PH_MASK: begin
        key_nxt = {key_r[23:0], item.data_byte};
        if (pos_e == 2'd3) begin
          pos_nxt = 2'd0;
          if (left_e == '0) begin
            phase_nxt = PH_FIRST;
            emit      = 1'b1;
            kind      = KIND_EMPTY;
            last      = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end else begin
          pos_nxt = pos_e + 2'd1;
        end
      end
      PH_DATA: begin
        last     = (left_e <= {{(LEN_W-1){1'b0}}, 1'b1});
        pos_nxt  = pos_e + 2'd1;
        left_nxt = left_e - {{(LEN_W-1){1'b0}}, 1'b1};
        emit     = 1'b1;
        kind     = KIND_DATA;
        pbyte    = item.data_byte ^ mask_byte;
        if (last) begin
          phase_nxt = PH_FIRST;
        end
      end
      PH_ERR: begin
        phase_nxt = PH_ERR;
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      ext_r    <= 3'd0;
      len_lo_r <= '0;
      len_hi_r <= 1'b0;
      key_r    <= 32'd0;
      pos_r    <= 2'd0;
      left_r   <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      ext_r    <= ext_nxt;
      len_lo_r <= len_lo_nxt;
      len_hi_r <= len_hi_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
      left_r   <= left_nxt;
    end
  end

  assign res.vld           = step_en && emit;
  assign res.kind          = kind;
  assign res.payload_byte  = pbyte;
  assign res.last_of_frame = last;
  assign err_hold          = (phase_r == PH_ERR);

endmodule : wsu_core

`default_nettype wire

// File: hdl/wsu_out_reg.sv
// Result register: holds one result until the downstream side takes it.
`default_nettype none

module wsu_out_reg
  import wsu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire result_t res,
  output logic         out_valid,
  output logic [1:0]   out_kind,
  output logic [7:0]   out_payload_byte,
  output logic         out_last_of_frame
);

  logic       vld_r;
  logic       vld_nxt;
  logic [1:0] kind_r;
  logic [7:0] byte_r;
  logic       last_r;

  assign vld_nxt = adv ? res.vld : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      kind_r <= res.kind;
      byte_r <= res.payload_byte;
      last_r <= res.last_of_frame;
    end
  end

  assign out_valid         = vld_r;
  assign out_kind          = kind_r;
  assign out_payload_byte  = byte_r;
  assign out_last_of_frame = last_r;

endmodule : wsu_out_reg

`default_nettype wire

// File: hdl/websocket_frame_unmasker.sv
// Path: an accepted byte waits in the input register, then steps the core into the result register.
// Throughput: one byte per clock; only the input register and the result register hold
//   an item, so a stalled result blocks input once one more byte waits behind it.
// Reset (rst_n low, synchronous): wait for a frame's first header byte, no byte or
//   result pending, max_payload back to 5120.
`default_nettype none

module websocket_frame_unmasker
  import wsu_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // byte stream in
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_restart,
  // results out
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_payload_byte,
  output logic                  out_last_of_frame,
  // max_payload register write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_max_payload
);

  logic             adv;        // result register can take the core's output
  logic             item_vld;
  in_item_t         item;
  logic             step_en;
  result_t          res;
  logic             err_hold;
  logic [LEN_W-1:0] max_payload_r;

  // Configuration: always ready; writes must arrive only while the block is idle, which the block leaves unchecked.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  // Advance the pipe whenever the result register is empty or being drained.
  // Every held byte steps the parser on advance, whether or not it makes a result.
  assign adv     = !out_valid || out_ready;
  assign step_en = item_vld && adv;

  // Capture one byte per transfer.
  wsu_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .adv          (adv),
    .item_vld     (item_vld),
    .item         (item)
  );

  // Parse header, collect mask, unmask payload.
  wsu_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .item        (item),
    .max_payload (max_payload_r),
    .res         (res),
    .err_hold    (err_hold)
  );

  // Hold the result until its transfer.
  wsu_out_reg u_out_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .res               (res),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_last_of_frame (out_last_of_frame)
  );

  // An empty frame result always closes its frame.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_EMPTY) |-> out_last_of_frame)
    else $error("empty frame result without last_of_frame");

  // Only payload results carry a byte.
  a_nondata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_DATA) |-> (out_payload_byte == 8'd0))
    else $error("non-payload result carries a nonzero byte");

  // A pending error result means the parser sits in its error hold.
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_kind == KIND_BADHEAD) || (out_kind == KIND_TOOLONG)) |-> err_hold)
    else $error("error result pending while parser left error hold");

  // A stalled output must stall the byte in the input register.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld && out_valid && !out_ready |=> item_vld && $stable(item))
    else $error("held byte lost while output stalled");

endmodule : websocket_frame_unmasker

`default_nettype wire

// File: test/tb_websocket_frame_unmasker.sv
// Testbench for websocket_frame_unmasker: random client frames against a byte-level predictor.
`timescale 1ns / 100ps

module tb_websocket_frame_unmasker;
  import wsu_pkg::*;

  // One byte of the client stream, with the sender's idle count in front of it
  typedef struct {
    logic [7:0] data;
    logic       restart;
    int         gap;
  } stream_byte_t;

  // One unmasker result as it should appear on the out_ ports
  typedef struct {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       last_of_frame;
  } ws_result_t;

  logic             clk;
  logic             rst_n             = 1'b0;
  logic             in_valid          = 1'b0;
  logic             in_ready;
  logic [7:0]       in_data_byte      = 8'h00;
  logic             in_restart        = 1'b0;
  logic             out_valid;
  logic             out_ready         = 1'b0;
  logic [1:0]       out_kind;
  logic [7:0]       out_payload_byte;
  logic             out_last_of_frame;
  logic             cfg_valid         = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_max_payload   = '0;

  websocket_frame_unmasker uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_payload   (cfg_max_payload)
  );

  // Stream bytes waiting for the driver, and results the predictor expects
  stream_byte_t tx_bytes[$];
  ws_result_t   predicted_out[$];

  // Predictor copy of the deframer state and its one register
  phase_t           ph       = PH_FIRST;
  logic [2:0]       ext_left = '0;
  logic [63:0]      flen     = '0;
  logic [31:0]      mkey     = '0;
  logic [1:0]       mpos     = '0;
  logic [LEN_W-1:0] left     = '0;
  logic [LEN_W-1:0] max_pl   = MAX_PAYLOAD_RST;

  // Handshake flags from the last rising edge, read by the falling-edge drivers
  logic in_took  = 1'b0;
  logic out_took = 1'b0;

  // Idle control: sender gaps are drawn at generation time, receiver stalls per result
  bit   gen_idle     = 1'b1;
  bit   out_idle_on  = 1'b1;
  logic out_hold     = 1'b0;
  bit   hold_go      = 1'b0;
  bit   need_restart = 1'b0;
  int   in_wait      = 0;
  int   out_wait     = 0;
  int   gen_count    = 0;

  int   bytes_in     = 0;
  int   results_seen = 0;
  int   mismatches   = 0;
  int   kind_seen[4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a result
  initial begin
    #1_000_000;
    $display("ERROR: run timed out with %0d results still expected", predicted_out.size());
    $display("TEST FAILED");
    $finish;
  end

  // Length is complete: flag it if over the limit, else arm the mask collection.
  function automatic void close_length();
    if (flen > {40'd0, max_pl}) begin
      ph = PH_ERR;
      predicted_out.push_back('{KIND_TOOLONG, 8'h00, 1'b0});
    end else begin
      left = flen[LEN_W-1:0];
      mpos = '0;
      mkey = '0;
      ph   = PH_MASK;
    end
  endfunction

  // Advance the predictor by one accepted stream byte.
  function automatic void deframe_byte(input logic [7:0] b, input logic rs);
    logic [6:0] code;
    logic [7:0] m;
    logic       last;
    if (rs) begin
      ph       = PH_FIRST;
      ext_left = '0;
      mpos     = '0;
      left     = '0;
    end
    case (ph)
      PH_FIRST: begin
        if (b != HDR_FIRST_BYTE) begin
          ph = PH_ERR;
          predicted_out.push_back('{KIND_BADHEAD, 8'h00, 1'b0});
        end else begin
          ph = PH_LEN;
        end
      end
      PH_LEN: begin
        code = b[6:0] & LEN_CODE_MASK[6:0];
        flen = '0;
        if (code <= LEN_MAX_DIRECT) begin
          flen = {57'd0, code};
          close_length();
        end else begin
          ext_left = (code == LEN_EXT16) ? EXT16_REMAIN : EXT64_REMAIN;
          ph       = PH_EXT;
        end
      end
      PH_EXT: begin
        flen = {flen[55:0], b};
        if (ext_left == 3'd0) close_length();
        else ext_left = ext_left - 3'd1;
      end
      PH_MASK: begin
        mkey = {mkey[23:0], b};
        if (mpos == 2'd3) begin
          mpos = '0;
          if (left == '0) begin
            ph = PH_FIRST;
            predicted_out.push_back('{KIND_EMPTY, 8'h00, 1'b1});
          end else begin
            ph = PH_DATA;
          end
        end else begin
          mpos = mpos + 2'd1;
        end
      end
      PH_DATA: begin
        m    = mkey[8 * (3 - mpos) +: 8];
        last = (left <= 1);
        mpos = mpos + 2'd1;
        left = left - 1'b1;
        if (last) ph = PH_FIRST;
        predicted_out.push_back('{KIND_DATA, b ^ m, last});
      end
      PH_ERR: ;
      default: ph = PH_ERR;
    endcase
  endfunction

  // Sample both channels at the rising edge; predict on input transfers, check output transfers.
  always @(posedge clk) begin : watch_channels
    ws_result_t want;
    in_took  <= rst_n && in_valid && in_ready;
    out_took <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      bytes_in++;
      deframe_byte(in_data_byte, in_restart);
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      kind_seen[out_kind]++;
      if (predicted_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result kind=%0d byte=%02h last=%0b",
                   out_kind, out_payload_byte, out_last_of_frame);
      end else begin
        want = predicted_out.pop_front();
        if (want.kind !== out_kind || want.payload_byte !== out_payload_byte ||
            want.last_of_frame !== out_last_of_frame) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: #%0d exp kind=%0d byte=%02h last=%0b got kind=%0d byte=%02h last=%0b",
                     results_seen, want.kind, want.payload_byte, want.last_of_frame,
                     out_kind, out_payload_byte, out_last_of_frame);
        end
      end
    end
  end

  // Sender: hold the current byte until its transfer, then wait out the next byte's gap.
  always @(negedge clk) begin : drive_stream
    stream_byte_t nxt;
    if (rst_n && !(in_valid && !in_took)) begin
      if (tx_bytes.size() != 0 && in_wait >= tx_bytes[0].gap) begin
        nxt          = tx_bytes.pop_front();
        in_data_byte <= nxt.data;
        in_restart   <= nxt.restart;
        in_valid     <= 1'b1;
        in_wait      = 0;
      end else begin
        in_valid <= 1'b0;
        if (tx_bytes.size() != 0) in_wait++;
      end
    end
  end

  // Receiver: draw a stall after every result transfer; the long hold overrides it.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_took) out_wait = out_idle_on ? $urandom_range(0, 18) : 0;
      else if (out_wait != 0) out_wait--;
      out_ready <= !out_hold && (out_wait == 0);
    end
  end

  // Long receiver hold-off while the sender keeps pushing, to back the block up.
  initial begin
    wait (hold_go);
    repeat (10) @(negedge clk);
    out_hold <= 1'b1;
    repeat (150) @(negedge clk);
    out_hold <= 1'b0;
  end

  task automatic push_byte(input logic [7:0] b, input logic rs);
    stream_byte_t it;
    it.data    = b;
    it.restart = rs;
    it.gap     = gen_idle ? $urandom_range(0, 18) : 0;
    tx_bytes.push_back(it);
    gen_count++;
  endtask

  // Queue one random frame: mostly well formed, sometimes noise or cut short.
  task automatic add_frame();
    logic [63:0] len;
    logic [6:0]  code;
    logic        rs;
    logic        broken;
    int          sel;
    int          form;
    int          pay;
    int          mcount;
    sel = $urandom_range(0, 99);
    rs  = need_restart || ($urandom_range(0, 7) == 0);
    if (sel < 6) begin
      // Noise: stray bytes that may land anywhere in the frame state
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'($urandom_range(0, 1)));
      need_restart = 1'b1;
      return;
    end
    sel  = $urandom_range(0, 99);
    form = 0;
    if (sel < 15) len = 0;
    else if (sel < 65) len = $urandom_range(1, 24);
    else if (sel < 80) len = $urandom_range(25, 125);
    else if (sel < 92) begin
      form = 1;
      len  = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 65535);
    end else begin
      form = 2;
      len  = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 40));
    end
    code = (form == 0) ? len[6:0] : (form == 1) ? LEN_EXT16 : LEN_EXT64;
    push_byte(HDR_FIRST_BYTE, rs);
    push_byte({1'($urandom_range(0, 1)), code}, 1'b0);
    if (form == 1) begin
      push_byte(len[15:8], 1'b0);
      push_byte(len[7:0], 1'b0);
    end else if (form == 2) begin
      for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8], 1'b0);
    end
    // Over the limit: the block drops into its error hold after the length
    if (len > {40'd0, max_pl}) begin
      need_restart = 1'b1;
      return;
    end
    broken = (len > 300) || ($urandom_range(0, 15) == 0);
    mcount = (broken && len == 0) ? $urandom_range(0, 3) : 4;
    repeat (mcount) push_byte(8'($urandom), 1'b0);
    if (!broken) pay = int'(len);
    else if (len == 0) pay = 0;
    else pay = $urandom_range(0, (len - 1 > 20) ? 20 : int'(len - 1));
    repeat (pay) push_byte(8'($urandom), 1'b0);
    need_restart = broken;
  endtask

  // Wait until every byte is transferred and every result checked, then let the pipe settle.
  task automatic drain_stream();
    while (tx_bytes.size() != 0 || in_valid || predicted_out.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_max_payload <= v;
    cfg_valid       <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_pl = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Fill the stream with random frames; idle_mode 0 = no gaps, 1 = gaps, 2 = per-frame mix.
  task automatic run_phase(input int n_items, input int idle_mode);
    out_idle_on = (idle_mode != 0);
    gen_count   = 0;
    while (gen_count < n_items) begin
      gen_idle = (idle_mode == 2) ? 1'($urandom_range(0, 1)) : (idle_mode == 1);
      add_frame();
    end
  endtask

  initial begin
    // Hold reset from the start, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bad first byte, ignored byte in the error hold, restart into an empty
    // frame with the mask bit set, a short frame without the mask bit, and a 64-bit
    // length with its top bit set
    gen_idle    = 1'b1;
    out_idle_on = 1'b1;
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(HDR_FIRST_BYTE, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(HDR_FIRST_BYTE, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(HDR_FIRST_BYTE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    repeat (7) push_byte(8'h00, 1'b0);
    need_restart = 1'b1;
    drain_stream();

    // Largest limit, no idling, and the long receiver stall on top
    write_max_payload({LEN_W{1'b1}});
    hold_go = 1'b1;
    run_phase(200, 0);
    drain_stream();

    // Zero limit: only empty frames get through
    write_max_payload('0);
    run_phase(80, 1);
    drain_stream();

    write_max_payload(24'd12);
    run_phase(150, 1);
    drain_stream();

    write_max_payload(LEN_W'($urandom));
    run_phase(200, 2);
    drain_stream();

    write_max_payload(MAX_PAYLOAD_RST);
    run_phase(150, 1);
    drain_stream();

    $display("Covered %0d bytes, %0d results: %0d data, %0d empty, %0d bad head, %0d too long",
             bytes_in, results_seen, kind_seen[KIND_DATA], kind_seen[KIND_EMPTY],
             kind_seen[KIND_BADHEAD], kind_seen[KIND_TOOLONG]);
    $display("Limits swept from zero to full scale, with one long output stall; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: websocket_frame_unmasker.f
hdl/wsu_pkg.sv
hdl/wsu_in_reg.sv
hdl/wsu_core.sv
hdl/wsu_out_reg.sv
hdl/websocket_frame_unmasker.sv
test/tb_websocket_frame_unmasker.sv
